FILE: rtl/ssp_pkg.sv
// Shared types and constants for the servo status packet receiver.
// No dependencies; imported by the interfaces, the parser and the top level.
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] SUM_GOOD  = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_LEN   = 8'd2;

    localparam logic [BYTE_W-1:0] EXPECTED_ID_RESET = 8'd1;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET  = 8'd40;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 1'b1;

    localparam logic KIND_PARAM = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_WRONG_ID  = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_SUM   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_ID   = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] param_index;
        status_t           packet_status;
        logic [BYTE_W-1:0] servo_error;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_id;
        logic [BYTE_W-1:0] max_length;
    } cfg_t;

endpackage

FILE: rtl/ssp_if.sv
// Valid/ready channel interfaces: received bytes in, parsed results out.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

interface ssp_rx_if;
    import ssp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssp_result_if;
    import ssp_pkg::*;

    logic              valid;
    logic              ready;
    logic              item_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] param_index;
    logic [1:0]        packet_status;
    logic [BYTE_W-1:0] servo_error;

    modport source (output valid, output item_kind, output data_byte,
                    output param_index, output packet_status,
                    output servo_error, input ready);
    modport sink   (input valid, input item_kind, input data_byte,
                    input param_index, input packet_status,
                    input servo_error, output ready);
endinterface

FILE: rtl/ssp_parser.sv
// Frame state and per-byte step of the status packet parser.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [ssp_pkg::BYTE_W-1:0] rx_byte,
    input  ssp_pkg::cfg_t            cfg,
    output logic                     res_valid,
    output ssp_pkg::result_t         res
);
    import ssp_pkg::*;

    phase_t            phase_reg,     phase_next;
    logic [BYTE_W-1:0] left_reg,      left_next;
    logic [BYTE_W-1:0] sum_reg,       sum_next;
    logic [BYTE_W-1:0] rid_reg,       rid_next;
    logic [BYTE_W-1:0] len_reg,       len_next;
    logic [BYTE_W-1:0] err_reg,       err_next;
    logic [BYTE_W-1:0] pos_reg,       pos_next;
    logic [BYTE_W-1:0] left_dec;

    function automatic status_t end_status(
        input logic [BYTE_W-1:0] id,
        input logic [BYTE_W-1:0] len,
        input logic              check_sum,
        input logic [BYTE_W-1:0] sum,
        input cfg_t              c
    );
        status_t st;
        if (id != c.expected_id)
            st = ST_WRONG_ID;
        else if (len < MIN_LEN || len > c.max_length)
            st = ST_BAD_LEN;
        else if (check_sum && sum != SUM_GOOD)
            st = ST_BAD_SUM;
        else
            st = ST_OK;
        return st;
    endfunction

    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        rid_next   = rid_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res        = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                phase_next = (rx_byte == SYNC_BYTE) ? PH_ID : PH_HUNT;
            end
            PH_ID:
            begin
                // skip repeated sync bytes; first other byte is the ID
                if (rx_byte != SYNC_BYTE)
                begin
                    rid_next   = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                len_next  = rx_byte;
                left_next = rx_byte;
                sum_next  = sum_reg + rx_byte;
                err_next  = '0;
                pos_next  = '0;
                if (rx_byte == '0)
                begin
                    // empty packet ends here without a checksum
                    phase_next        = PH_HUNT;
                    res_valid         = 1'b1;
                    res.item_kind     = KIND_END;
                    res.packet_status = end_status(rid_reg, rx_byte, 1'b0,
                                                   sum_next, cfg);
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                sum_next  = sum_reg + rx_byte;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next        = PH_HUNT;
                    res_valid         = 1'b1;
                    res.item_kind     = KIND_END;
                    res.servo_error   = err_reg;
                    res.packet_status = end_status(rid_reg, len_reg, 1'b1,
                                                   sum_next, cfg);
                end
                else if (pos_reg == '0)
                begin
                    err_next = rx_byte;
                    pos_next = 8'd1;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.item_kind   = KIND_PARAM;
                    res.data_byte   = rx_byte;
                    res.param_index = pos_reg - 8'd1;
                    pos_next        = pos_reg + 8'd1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            sum_reg   <= '0;
            rid_reg   <= '0;
            len_reg   <= '0;
            err_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            rid_reg   <= rid_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> left_reg != '0)
        else $error("body phase with no bytes left");

    a_param_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res.item_kind == KIND_PARAM
        |-> phase_reg == PH_BODY && pos_reg != '0)
        else $error("parameter emitted before the error byte");
`endif

endmodule

FILE: rtl/servo_status_packet_receiver.sv
// Top level of the servo status packet receiver: config registers,
// result register and channel handshake. Depends on ssp_pkg, ssp_if, ssp_parser.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Request
// rx        in   rx_byte                                          one bus byte
// result    out  item_kind data_byte param_index packet_status    one parameter
//                servo_error                                      or end status
// cfg       in   cfg_wr_en cfg_index cfg_data                     register write
//
// The parser's frame state updates and the result register loads in the same
// cycle, so a byte can be taken every clock while rx.ready is high.
// rx.ready drops only while the result register is full and result.ready is
// low; take a new byte in the cycle the held request leaves.
// Reset clears the frame state to hunting for a sync byte and loads the
// register defaults (expected_id 1, max_length 40).

module servo_status_packet_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    ssp_rx_if.sink                          rx,
    ssp_result_if.source                    result,
    input  logic                            cfg_wr_en,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssp_pkg::BYTE_W-1:0]      cfg_data
);
    import ssp_pkg::*;

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    accept;
    logic    res_valid;
    result_t res;

    // Advance when the result slot is empty or being drained this cycle.
    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    // Register writes; applied straight away, the next end status sees them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_id <= EXPECTED_ID_RESET;
            cfg_reg.max_length  <= MAX_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_ID: cfg_reg.expected_id <= cfg_data;
                CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    ssp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: fill on an accepted byte that yields a request,
    // drop the request once the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= res_valid;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload holds while stalled since accept is low then.
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_res_reg <= res;
    end

    assign result.valid         = out_valid_reg;
    assign result.item_kind     = out_res_reg.item_kind;
    assign result.data_byte     = out_res_reg.data_byte;
    assign result.param_index   = out_res_reg.param_index;
    assign result.packet_status = out_res_reg.packet_status;
    assign result.servo_error   = out_res_reg.servo_error;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !out_valid_reg || result.ready)
        else $error("byte accepted over a held request");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid |=> out_valid_reg)
        else $error("result request lost");
`endif

endmodule

FILE: tb/sv/servo_status_packet_receiver_test.sv
`timescale 1ns / 1ps
// Self-checking bench for servo_status_packet_receiver: bus bytes in with random gaps,
// parsed requests out under random back-pressure, each one checked against a predictor.
// Depends on ssp_pkg, ssp_if and the receiver RTL.

module servo_status_packet_receiver_test;
    import ssp_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either channel
    localparam int DRAIN_CYCLES = 4;     // settling wait after every predicted request has come out
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BYTES = 1050;
    localparam int N_PLAN       = 7;

    // One row of the directed part: a bus byte, and where the answer is obvious,
    // the request it must produce.
    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        bit                typed;
        result_t           want;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPECTED_ID;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    ssp_rx_if     rx_ch ();
    ssp_result_if res_ch ();

    servo_status_packet_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Predictor: frame state and register copies, updated on every accepted byte
    // and every register write.
    phase_t            ph;
    logic [BYTE_W-1:0] left_cnt;
    logic [BYTE_W-1:0] sum_acc;
    logic [BYTE_W-1:0] got_id;
    logic [BYTE_W-1:0] got_len;
    logic [BYTE_W-1:0] got_err;
    logic [BYTE_W-1:0] param_pos;
    logic [BYTE_W-1:0] want_id;
    logic [BYTE_W-1:0] len_limit;

    result_t pending_replies [$];   // predicted requests, oldest first
    int      fail_count  = 0;
    int      bytes_sent  = 0;
    int      idle_cycles = 0;
    bit      no_idle     = 1'b0;    // both sides run flat out while set

    function automatic result_t end_rep(input status_t st, input logic [BYTE_W-1:0] err);
        result_t r;
        r               = '0;
        r.item_kind     = KIND_END;
        r.packet_status = st;
        r.servo_error   = err;
        return r;
    endfunction

    function automatic stim_row_t plain(input logic [BYTE_W-1:0] b);
        stim_row_t row;
        row.rx_byte = b;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic stim_row_t checked(input logic [BYTE_W-1:0] b, input result_t want);
        stim_row_t row;
        row.rx_byte = b;
        row.typed   = 1'b1;
        row.want    = want;
        return row;
    endfunction

    // Wrong ID beats bad length, which beats bad checksum.
    function automatic status_t packet_verdict(input bit sum_checked);
        if (got_id != want_id)
            return ST_WRONG_ID;
        if (got_len < MIN_LEN || got_len > len_limit)
            return ST_BAD_LEN;
        if (sum_checked && sum_acc != SUM_GOOD)
            return ST_BAD_SUM;
        return ST_OK;
    endfunction

    // Advance the frame state by one bus byte; return 1 with the request it causes.
    function automatic bit parse_bus_byte(input logic [BYTE_W-1:0] b, output result_t rep);
        rep = '0;
        case (ph)
            PH_ID:
            begin
                // Skip extra sync bytes; the first other byte is the ID.
                if (b != SYNC_BYTE)
                begin
                    got_id  = b;
                    sum_acc = b;
                    ph      = PH_LEN;
                end
                return 1'b0;
            end
            PH_LEN:
            begin
                got_len   = b;
                left_cnt  = b;
                sum_acc   = sum_acc + b;
                got_err   = '0;
                param_pos = '0;
                if (b == '0)
                begin
                    // Zero length closes the packet at once, no checksum.
                    ph  = PH_HUNT;
                    rep = end_rep(packet_verdict(1'b0), '0);
                    return 1'b1;
                end
                ph = PH_BODY;
                return 1'b0;
            end
            PH_BODY:
            begin
                sum_acc  = sum_acc + b;
                left_cnt = left_cnt - 8'd1;
                if (left_cnt == '0)
                begin
                    ph  = PH_HUNT;
                    rep = end_rep(packet_verdict(1'b1), got_err);
                    return 1'b1;
                end
                if (param_pos == '0)
                begin
                    got_err   = b;
                    param_pos = 8'd1;
                    return 1'b0;
                end
                rep.item_kind   = KIND_PARAM;
                rep.data_byte   = b;
                rep.param_index = param_pos - 8'd1;
                param_pos       = param_pos + 8'd1;
                return 1'b1;
            end
            default:
            begin
                ph = (b == SYNC_BYTE) ? PH_ID : PH_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want)
            log_failure($sformatf("%s mismatch, expected %0h, got %0h", name, want, got));
    endtask

    // Offer one byte after a random gap and hold it until taken. Enter and leave
    // at a falling edge; valid stays high on return, so the caller either offers
    // the next byte in the same step or drops valid.
    task automatic send_byte(input stim_row_t row);
        int unsigned gap;
        result_t     rep;
        bit          hit;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = row.rx_byte;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
        hit = parse_bus_byte(row.rx_byte, rep);
        // Typed rows carry their own answer; the predictor still tracks the frame.
        if (row.typed)
            pending_replies.push_back(row.want);
        else if (hit)
            pending_replies.push_back(rep);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted request has come out.
    task automatic drain_replies();
        rx_ch.valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_EXPECTED_ID)
            want_id = val;
        else
            len_limit = val;
    endtask

    // One status packet with random content. Mostly well formed; sometimes led by
    // noise, with a bad checksum, an odd or overlong length, or cut short so that
    // the next packet's bytes land in its body.
    task automatic send_packet();
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int unsigned       r;
        int                lim;
        int                n_body;
        lim = int'(len_limit);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) send_byte(plain(8'($urandom_range(0, 254))));
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
            send_byte(plain(SYNC_BYTE));

        if (want_id != SYNC_BYTE && $urandom_range(0, 99) < 85)
            id = want_id;
        else
            id = 8'($urandom_range(0, 254));

        r = $urandom_range(0, 99);
        if (r < 8)
            len = 8'($urandom_range(0, 1));
        else if (r < 18)
            len = (lim == 255) ? 8'($urandom_range(2, 12))
                               : 8'($urandom_range(lim + 1, (lim > 249) ? 255 : lim + 6));
        else if (r < 20)
            len = 8'($urandom_range(2, 255));
        else
            len = 8'($urandom_range(2, (lim < 2) ? 6 : ((lim > 12) ? 12 : lim)));

        send_byte(plain(id));
        send_byte(plain(len));
        sum    = id + len;
        n_body = int'(len);
        if (n_body != 0 && $urandom_range(0, 19) == 0)
            n_body = $urandom_range(0, n_body - 1);
        for (int i = 0; i < n_body; i++)
        begin
            // Last body byte is the checksum: make it right most of the time.
            if (i == int'(len) - 1)
                b = ($urandom_range(0, 4) != 0) ? ~sum : 8'($urandom);
            else
                b = 8'($urandom);
            sum = sum + b;
            send_byte(plain(b));
        end
    endtask

    // Stimulus: reset, directed rows, then random packets over several register settings.
    initial
    begin
        stim_row_t         stim [$];
        logic [BYTE_W-1:0] plan_id [N_PLAN];
        logic [BYTE_W-1:0] plan_len [N_PLAN];
        int                target;

        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        ph            = PH_HUNT;
        left_cnt      = '0;
        sum_acc       = '0;
        got_id        = '0;
        got_len       = '0;
        got_err       = '0;
        param_pos     = '0;
        want_id       = EXPECTED_ID_RESET;
        len_limit     = MAX_LENGTH_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        stim = '{
            // stray byte while hunting
            plain(8'h00),
            // zero length ends the packet at the length byte
            plain(SYNC_BYTE), plain(8'h01), checked(8'h00, end_rep(ST_BAD_LEN, 8'h00)),
            // wrong ID outranks the length error
            plain(SYNC_BYTE), plain(8'hFE), checked(8'h00, end_rep(ST_WRONG_ID, 8'h00)),
            // length one: the lone body byte is the checksum
            plain(SYNC_BYTE), plain(8'h01), plain(8'h01),
            checked(8'h55, end_rep(ST_BAD_LEN, 8'h00)),
            // checksum off
            plain(SYNC_BYTE), plain(8'h01), plain(8'h02), plain(8'h00),
            checked(8'h00, end_rep(ST_BAD_SUM, 8'h00)),
            // doubled sync, all-ones error and parameter bytes
            plain(SYNC_BYTE), plain(SYNC_BYTE), plain(8'h01), plain(8'h03),
            plain(8'hFF), plain(8'hFF), plain(8'hFD),
            // clean minimum packet
            plain(SYNC_BYTE), plain(8'h01), plain(8'h02), plain(8'h00),
            checked(8'hFC, end_rep(ST_OK, 8'h00))
        };
        foreach (stim[i])
            send_byte(stim[i]);

        // Phase 0 keeps the reset values; the rest cover both ends of each register,
        // IDs that no servo can answer with, and length limits below two.
        plan_id  = '{EXPECTED_ID_RESET, 8'd0, 8'd253, 8'd254,
                     8'($urandom_range(0, 253)), 8'hFF, 8'($urandom_range(0, 253))};
        plan_len = '{MAX_LENGTH_RESET, 8'd2, 8'd255, 8'd1,
                     8'($urandom_range(2, 255)), 8'd0, MAX_LENGTH_RESET};

        for (int p = 0; p < N_PLAN; p++)
        begin
            // Registers change only with nothing in flight; this also makes the
            // sender hold until every request has come.
            if (p != 0)
            begin
                drain_replies();
                write_reg(CFG_EXPECTED_ID, plan_id[p]);
                write_reg(CFG_MAX_LENGTH, plan_len[p]);
            end
            target = bytes_sent + RANDOM_BYTES / N_PLAN;
            while (bytes_sent < target)
                send_packet();
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("servo_status_packet_receiver test passed");
        else
            $display("servo_status_packet_receiver test failed");
        $finish;
    end

    // Result side: stall a random number of cycles per request, then take it and
    // compare every field with the oldest prediction.
    initial
    begin
        int unsigned stall;
        result_t     want;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            if (pending_replies.size() == 0)
                log_failure($sformatf("unexpected request, expected none, got kind %0h data %0h",
                                      res_ch.item_kind, res_ch.data_byte));
            else
            begin
                want = pending_replies.pop_front();
                check_field("item_kind", {7'd0, want.item_kind}, {7'd0, res_ch.item_kind});
                check_field("data_byte", want.data_byte, res_ch.data_byte);
                check_field("param_index", want.param_index, res_ch.param_index);
                check_field("packet_status", {6'd0, want.packet_status},
                            {6'd0, res_ch.packet_status});
                check_field("servo_error", want.servo_error, res_ch.servo_error);
            end
            @(negedge clk);
        end
    end

    // Set both sides anew to random idling or full rate at random intervals.
    initial
    begin
        forever
        begin
            repeat ($urandom_range(40, 300)) @(negedge clk);
            no_idle = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: end the run once neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("servo_status_packet_receiver test failed");
            $finish;
        end
    end

endmodule
